// ----- src/rci_pkg.sv -----
// shared types, constants and saturating helpers for the ray/cone intersection block
package rci_pkg;

  // default number of fraction bits of every fixed-point value
  localparam int FRAC_BITS_DEF = 16;

  // pipeline depth of the saturating fixed-point multiplier
  localparam int MUL_LAT = 4;

  // pipeline depth of the saturating fixed-point divider
  localparam int DIV_LAT = 65;

  // configuration port geometry
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam int CFG_W  = 31;

  // register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // internal signed 64-bit fixed-point word
  typedef logic signed [63:0] fx_t;

  localparam fx_t WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // cone geometry as programmed
  typedef struct packed {
    logic [CFG_W-1:0] radius;
    logic [CFG_W-1:0] height;
  } cone_cfg_t;

  // symmetric saturating add to +-WMAX
  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (!s[64] && s[63]) begin
      return WMAX;
    end else if (s[64] && (!s[63] || (s[62:0] == 63'd0))) begin
      return -WMAX;
    end
    return s[63:0];
  endfunction

  // magnitude as an unsigned word
  function automatic logic [63:0] mag64(fx_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // clamp to a signed 32-bit result field
  function automatic logic signed [31:0] sat32(fx_t x);
    if (!x[63] && (x[62:31] != 32'd0)) begin
      return 32'sh7FFF_FFFF;
    end else if (x[63] && (x[62:31] != 32'hFFFF_FFFF)) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- src/rci_in_if.sv -----
// ray input channel: valid/ready handshake with the ray fields
interface rci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic               ray_inside;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_inside,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_inside,
    output ready
  );
endinterface

// ----- src/rci_out_if.sv -----
// hit result channel: valid/ready handshake with the hit fields
interface rci_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [30:0]        hit_t;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;

  modport source (
    output valid, hit, hit_t, point_x, point_y, point_z, grad_x, grad_y, grad_z,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_t, point_x, point_y, point_z, grad_x, grad_y, grad_z,
    output ready
  );
endinterface

// ----- src/rci_delay.sv -----
// enabled shift line that carries pipeline payload between stages
module rci_delay #(
  parameter int W     = 64,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] line_r [DEPTH];

  // shift on every advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[DEPTH-1];
endmodule

// ----- src/rci_fmul.sv -----
// four-stage saturating signed fixed-point multiplier built from 32x32 partial products
module rci_fmul #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  rci_pkg::fx_t a,
  input  rci_pkg::fx_t b,
  output rci_pkg::fx_t p
);
  import rci_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  pll_r, plh_r, phl_r, phh_r;
  logic [127:0] prod_r;
  fx_t          p_r;
  logic [127:0] prod_nxt;
  logic [63:0]  m;
  logic         ovf;
  fx_t          msat;

  // sum of the partial products
  always_comb begin
    prod_nxt = {64'd0, pll_r} + {32'd0, plh_r, 32'd0} + {32'd0, phl_r, 32'd0}
             + {phh_r, 64'd0};
  end

  // scale, saturate and restore the sign
  always_comb begin
    m    = prod_r[FRAC_BITS+63:FRAC_BITS];
    ovf  = |prod_r[127:FRAC_BITS+64];
    msat = (ovf || m[63]) ? WMAX : fx_t'(m);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= mag64(a);
      mb_r   <= mag64(b);
      neg1_r <= a[63] ^ b[63];
      pll_r  <= 64'(ma_r[31:0])  * 64'(mb_r[31:0]);
      plh_r  <= 64'(ma_r[31:0])  * 64'(mb_r[63:32]);
      phl_r  <= 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
      phh_r  <= 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
      neg2_r <= neg1_r;
      prod_r <= prod_nxt;
      neg3_r <= neg2_r;
      p_r    <= neg3_r ? -msat : msat;
    end
  end

  assign p = p_r;
endmodule

// ----- src/rci_div.sv -----
// pipelined restoring divider, one quotient bit per stage, saturating to +-WMAX
module rci_div #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  rci_pkg::fx_t x,
  input  rci_pkg::fx_t y,
  output rci_pkg::fx_t q
);
  import rci_pkg::*;

  localparam int QB = 63;
  localparam int SH = 63 - FRAC_BITS;

  logic [63:0] rem_r [QB+1];
  logic [62:0] quo_r [QB+1];
  logic [62:0] num_r [QB+1];
  logic [63:0] den_r [QB+1];
  logic        neg_r [QB+1];
  logic        ovf_r [QB+1];
  fx_t         q_r;

  logic [63:0] nx, dy, rem0;
  logic [63:0] rs [1:QB];
  logic        ge [1:QB];
  fx_t         qv;

  // entry: magnitudes, overflow check on the top quotient bits
  always_comb begin
    nx   = mag64(x);
    dy   = mag64(y);
    rem0 = nx >> SH;
  end

  // compare-subtract of each stage
  always_comb begin
    for (int i = 1; i <= QB; i++) begin
      rs[i] = {rem_r[i-1][62:0], num_r[i-1][62]};
      ge[i] = rs[i] >= den_r[i-1];
    end
  end

  always_comb begin
    qv = ovf_r[QB] ? WMAX : fx_t'({1'b0, quo_r[QB]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      quo_r[0] <= '0;
      num_r[0] <= {nx[SH-1:0], {FRAC_BITS{1'b0}}};
      den_r[0] <= dy;
      neg_r[0] <= x[63] ^ y[63];
      ovf_r[0] <= (dy == 64'd0) || (rem0 >= dy);
      for (int i = 1; i <= QB; i++) begin
        rem_r[i] <= ge[i] ? (rs[i] - den_r[i-1]) : rs[i];
        quo_r[i] <= {quo_r[i-1][61:0], ge[i]};
        num_r[i] <= {num_r[i-1][61:0], 1'b0};
        den_r[i] <= den_r[i-1];
        neg_r[i] <= neg_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
      q_r <= neg_r[QB] ? -qv : qv;
    end
  end

  assign q = q_r;
endmodule

// ----- src/rci_sqrt.sv -----
// pipelined digit-by-digit square root of (v << FRAC_BITS), one root bit per stage
module rci_sqrt #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  rci_pkg::fx_t v,
  output rci_pkg::fx_t s
);
  import rci_pkg::*;

  localparam int SB = (63 + FRAC_BITS) / 2 + 2;
  localparam int RW = 2 * SB;

  logic [RW-1:0] rad_r  [SB+1];
  logic [SB+1:0] rem_r  [SB+1];
  logic [SB-1:0] root_r [SB+1];

  logic [SB+1:0] rem2  [1:SB];
  logic [SB+1:0] trial [1:SB];
  logic          ge    [1:SB];

  // trial subtraction of each stage
  always_comb begin
    for (int i = 1; i <= SB; i++) begin
      rem2[i]  = {rem_r[i-1][SB-1:0], rad_r[i-1][RW-1:RW-2]};
      trial[i] = {root_r[i-1], 2'b01};
      ge[i]    = rem2[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= RW'({v, {FRAC_BITS{1'b0}}});
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int i = 1; i <= SB; i++) begin
        rad_r[i]  <= {rad_r[i-1][RW-3:0], 2'b00};
        rem_r[i]  <= ge[i] ? (rem2[i] - trial[i]) : rem2[i];
        root_r[i] <= {root_r[i-1][SB-2:0], ge[i]};
      end
    end
  end

  assign s = fx_t'({{(64-SB){1'b0}}, root_r[SB]});
endmodule

// ----- src/rci_kcalc.sv -----
// sequencer that recomputes k = (radius / height)^2 after a register write
module rci_kcalc #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rci_pkg::cone_cfg_t cfg,
  output rci_pkg::fx_t      k,
  output logic              busy
);
  import rci_pkg::*;

  localparam int NB = CFG_W + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [NB-1:0]    num_r, num_nxt;
  logic [NB-1:0]    quo_r, quo_nxt;
  logic [CFG_W:0]   rem_r, rem_nxt;
  logic [CFG_W-1:0] den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  fx_t              k_r, k_nxt;
  logic [CFG_W:0]   rem_sh;
  logic             ge;
  fx_t              ratio, prod;

  // radius over height, saturated for a zero height
  assign ratio = (den_r == '0) ? WMAX : fx_t'({{(64-NB){1'b0}}, quo_r});

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_sq (
    .clk (clk),
    .en  (1'b1),
    .a   (ratio),
    .b   (ratio),
    .p   (prod)
  );

  // one quotient bit per cycle, then wait out the multiplier; a new write restarts
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    rem_sh    = {rem_r[CFG_W-1:0], num_r[NB-1]};
    ge        = rem_sh >= {1'b0, den_r};
    if (start) begin
      num_nxt   = {cfg.radius, {FRAC_BITS{1'b0}}};
      den_nxt   = cfg.height;
      quo_nxt   = '0;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      state_nxt = ST_DIV;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          state_nxt = ST_IDLE;
        end
        ST_DIV: begin
          rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
          quo_nxt = {quo_r[NB-2:0], ge};
          num_nxt = {num_r[NB-2:0], 1'b0};
          if (cnt_r == CW'(NB - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        ST_MUL: begin
          if (cnt_r == CW'(MUL_LAT)) begin
            k_nxt     = prod;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= fx_t'(64'd1 << FRAC_BITS);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign k    = k_r;
  assign busy = state_r != ST_IDLE;
endmodule

// ----- src/ray_cone_intersect.sv -----
// top level: ray against cone intersection pipeline with APB register port
//
// Rays enter on in_ch (valid/ready, one transfer per ray) and each gives exactly
// one result transfer on out_ch: hit flag, ray parameter t, hit point and the
// unnormalized gradient, all Q16.16 and saturated; a miss returns all zeros.
// The pipeline takes a new ray every cycle while out_ch is not stalled and no
// recompute is running. The square-root and divider stages, which resolve one
// result bit per stage, make up most of its depth.
// The whole pipeline advances together; when out_ch is stalled with a result
// waiting, every stage holds and in_ch.ready drops, so nothing is lost.
// cone_radius (0x0) and cone_height (0x4) reset to 1.0. Each write starts a
// fresh recompute of (radius/height)^2, during which in_ch.ready is low.
// Registers are to be written only while idle, by the user; the block does not enforce it.
// After reset the block accepts rays at once.
module ray_cone_intersect #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rci_in_if.sink                    in_ch,
  rci_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rci_pkg::CFG_AW-1:0] paddr,
  input  logic [rci_pkg::CFG_DW-1:0] pwdata,
  output logic [rci_pkg::CFG_DW-1:0] prdata,
  output logic                      pready
);
  import rci_pkg::*;

  localparam int LM  = MUL_LAT;
  localparam int SQL = (63 + FRAC_BITS) / 2 + 3;
  localparam int DVL = DIV_LAT;

  // pipeline positions of each step
  localparam int P1  = LM;
  localparam int P2  = P1 + LM;
  localparam int P3  = P2 + 1;
  localparam int P4  = P3 + 1;
  localparam int P5  = P4 + LM;
  localparam int P6  = P5 + 3;
  localparam int P7  = P6 + 1;
  localparam int P8  = P6 + SQL;
  localparam int P9  = P8 + 1;
  localparam int P10 = P9 + DVL;
  localparam int P11 = P10 + 1;
  localparam int P12 = P11 + LM;
  localparam int P13 = P12 + 1;
  localparam int P14 = P13 + 1;
  localparam int P15 = P14 + LM;
  localparam int P16 = P15 + 1;

  // configuration registers
  logic [CFG_W-1:0] radius_r, height_r;
  logic             wr_en, start_r;
  cone_cfg_t        cfg;
  fx_t              k;
  logic             k_busy;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= CFG_W'(64'd1 << FRAC_BITS);
      height_r <= CFG_W'(64'd1 << FRAC_BITS);
      start_r  <= 1'b0;
    end else begin
      start_r <= wr_en;
      if (wr_en) begin
        unique case (paddr[2])
          REG_RADIUS: radius_r <= pwdata[CFG_W-1:0];
          REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
          default:    radius_r <= radius_r;
        endcase
      end
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_RADIUS: prdata = {1'b0, radius_r};
      REG_HEIGHT: prdata = {1'b0, height_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.radius = radius_r;
  assign cfg.height = height_r;

  rci_kcalc #(.FRAC_BITS(FRAC_BITS)) u_kcalc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .cfg   (cfg),
    .k     (k),
    .busy  (k_busy)
  );

  // global advance and valid line
  logic [P16:0] vld_r;
  logic         adv, acc;
  fx_t          h64;

  assign adv          = !vld_r[P16] || out_ch.ready;
  assign in_ch.ready  = adv && !k_busy && !start_r;
  assign acc          = in_ch.valid && in_ch.ready;
  assign h64          = fx_t'({33'd0, height_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[P16-1:0], acc};
    end
  end

  // input stage
  fx_t  ox0_r, oy0_r, oz0_r, dx0_r, dy0_r, dz0_r, hy0_r;
  logic in0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ox0_r <= fx_t'(in_ch.origin_x);
      oy0_r <= fx_t'(in_ch.origin_y);
      oz0_r <= fx_t'(in_ch.origin_z);
      dx0_r <= fx_t'(in_ch.dir_x);
      dy0_r <= fx_t'(in_ch.dir_y);
      dz0_r <= fx_t'(in_ch.dir_z);
      hy0_r <= h64 - fx_t'(in_ch.origin_y);
      in0_r <= in_ch.ray_inside;
    end
  end

  // first products
  fx_t dxdx, dzdz, dydy, hydy, oxdx, ozdz, oxox, ozoz, hyhy;

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_dxdx (.clk(clk), .en(adv), .a(dx0_r), .b(dx0_r), .p(dxdx));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_dzdz (.clk(clk), .en(adv), .a(dz0_r), .b(dz0_r), .p(dzdz));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_dydy (.clk(clk), .en(adv), .a(dy0_r), .b(dy0_r), .p(dydy));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_hydy (.clk(clk), .en(adv), .a(hy0_r), .b(dy0_r), .p(hydy));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_oxdx (.clk(clk), .en(adv), .a(ox0_r), .b(dx0_r), .p(oxdx));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_ozdz (.clk(clk), .en(adv), .a(oz0_r), .b(dz0_r), .p(ozdz));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_oxox (.clk(clk), .en(adv), .a(ox0_r), .b(ox0_r), .p(oxox));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_ozoz (.clk(clk), .en(adv), .a(oz0_r), .b(oz0_r), .p(ozoz));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_hyhy (.clk(clk), .en(adv), .a(hy0_r), .b(hy0_r), .p(hyhy));

  // partial sums, then aligned with the k products
  fx_t s1_r, s2_r, s3_r, s1_d, s2_d, s3_d;
  fx_t kdydy, khydy, khyhy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= sat_add(dxdx, dzdz);
      s2_r <= sat_add(oxdx, ozdz);
      s3_r <= sat_add(oxox, ozoz);
    end
  end

  rci_delay #(.W(192), .DEPTH(LM - 1)) u_d_s (
    .clk(clk), .en(adv), .d({s1_r, s2_r, s3_r}), .q({s1_d, s2_d, s3_d})
  );

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_kdydy (.clk(clk), .en(adv), .a(k), .b(dydy), .p(kdydy));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_khydy (.clk(clk), .en(adv), .a(k), .b(hydy), .p(khydy));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_khyhy (.clk(clk), .en(adv), .a(k), .b(hyhy), .p(khyhy));

  // quadratic coefficients
  fx_t a3_r, b3_r, c3_r, a4_r, b4_r, c4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_r <= sat_add(s1_d, -kdydy);
      b3_r <= sat_add(khydy, s2_d);
      c3_r <= sat_add(s3_d, -khyhy);
      a4_r <= a3_r;
      b4_r <= sat_add(b3_r, b3_r);
      c4_r <= c3_r;
    end
  end

  // discriminant
  fx_t ac, bb, bb_d, ac2_r, ac4_r, disc_r, a6, b6;

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_ac (.clk(clk), .en(adv), .a(a4_r), .b(c4_r), .p(ac));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_bb (.clk(clk), .en(adv), .a(b4_r), .b(b4_r), .p(bb));

  rci_delay #(.W(64), .DEPTH(2)) u_d_bb (.clk(clk), .en(adv), .d(bb), .q(bb_d));
  rci_delay #(.W(128), .DEPTH(P6 - P4)) u_d_ab (
    .clk(clk), .en(adv), .d({a4_r, b4_r}), .q({a6, b6})
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ac2_r  <= sat_add(ac, ac);
      ac4_r  <= sat_add(ac2_r, ac2_r);
      disc_r <= sat_add(bb_d, -ac4_r);
    end
  end

  // miss check, denominator and negated b
  logic miss7_r, miss8;
  fx_t  den7_r, negb7_r, den8, negb8, sq8;

  always_ff @(posedge clk) begin
    if (adv) begin
      miss7_r <= disc_r[63] || (a6 == '0);
      den7_r  <= sat_add(a6, a6);
      negb7_r <= -b6;
    end
  end

  rci_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (.clk(clk), .en(adv), .v(disc_r), .s(sq8));

  rci_delay #(.W(129), .DEPTH(P8 - P7)) u_d_p7 (
    .clk(clk), .en(adv), .d({miss7_r, den7_r, negb7_r}), .q({miss8, den8, negb8})
  );

  // root numerators
  fx_t nlo9_r, nhi9_r, den9_r, tlo, thi;

  always_ff @(posedge clk) begin
    if (adv) begin
      nlo9_r <= sat_add(negb8, -sq8);
      nhi9_r <= sat_add(negb8, sq8);
      den9_r <= den8;
    end
  end

  rci_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (.clk(clk), .en(adv), .x(nlo9_r), .y(den9_r), .q(tlo));
  rci_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (.clk(clk), .en(adv), .x(nhi9_r), .y(den9_r), .q(thi));

  logic miss10, in10;

  rci_delay #(.W(1), .DEPTH(P10 - P8)) u_d_m8 (.clk(clk), .en(adv), .d(miss8), .q(miss10));
  rci_delay #(.W(1), .DEPTH(P10)) u_d_in (.clk(clk), .en(adv), .d(in0_r), .q(in10));

  // root selection
  fx_t  t11_r, tmin, tmax, tsel;
  logic miss11_r;

  always_comb begin
    tmin = (tlo > thi) ? thi : tlo;
    tmax = (tlo > thi) ? tlo : thi;
    tsel = in10 ? tmax : tmin;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t11_r    <= tsel;
      miss11_r <= miss10 || tsel[63];
    end
  end

  // hit point
  fx_t dx11, dy11, dz11, ox12, oy12, oz12, dxt, dyt, dzt;

  rci_delay #(.W(192), .DEPTH(P11)) u_d_dir (
    .clk(clk), .en(adv), .d({dx0_r, dy0_r, dz0_r}), .q({dx11, dy11, dz11})
  );
  rci_delay #(.W(192), .DEPTH(P12)) u_d_org (
    .clk(clk), .en(adv), .d({ox0_r, oy0_r, oz0_r}), .q({ox12, oy12, oz12})
  );

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_dxt (.clk(clk), .en(adv), .a(dx11), .b(t11_r), .p(dxt));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_dyt (.clk(clk), .en(adv), .a(dy11), .b(t11_r), .p(dyt));
  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_dzt (.clk(clk), .en(adv), .a(dz11), .b(t11_r), .p(dzt));

  fx_t  px13_r, py13_r, pz13_r, px14_r, py14_r, pz14_r, pyh14_r;
  logic miss13, miss14_r;

  rci_delay #(.W(1), .DEPTH(P13 - P11)) u_d_m11 (
    .clk(clk), .en(adv), .d(miss11_r), .q(miss13)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      px13_r   <= sat_add(ox12, dxt);
      py13_r   <= sat_add(oy12, dyt);
      pz13_r   <= sat_add(oz12, dzt);
      px14_r   <= px13_r;
      py14_r   <= py13_r;
      pz14_r   <= pz13_r;
      pyh14_r  <= py13_r - h64;
      miss14_r <= miss13 || py13_r[63] || (py13_r > h64);
    end
  end

  // gradient y and alignment of the rest
  fx_t  gy15, px15, py15, pz15, t15;
  logic miss15;

  rci_fmul #(.FRAC_BITS(FRAC_BITS)) u_m_gy (.clk(clk), .en(adv), .a(k), .b(pyh14_r), .p(gy15));

  rci_delay #(.W(193), .DEPTH(P15 - P14)) u_d_p14 (
    .clk(clk), .en(adv), .d({miss14_r, px14_r, py14_r, pz14_r}),
    .q({miss15, px15, py15, pz15})
  );
  rci_delay #(.W(64), .DEPTH(P15 - P11)) u_d_t (
    .clk(clk), .en(adv), .d(t11_r), .q(t15)
  );

  // output register
  logic               hit_r;
  logic [30:0]        hit_t_r;
  logic signed [31:0] px_r, py_r, pz_r, gy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= !miss15;
      if (miss15) begin
        hit_t_r <= '0;
        px_r    <= '0;
        py_r    <= '0;
        pz_r    <= '0;
        gy_r    <= '0;
      end else begin
        hit_t_r <= (t15[63:31] != '0) ? 31'h7FFF_FFFF : t15[30:0];
        px_r    <= sat32(px15);
        py_r    <= sat32(py15);
        pz_r    <= sat32(pz15);
        gy_r    <= sat32(gy15);
      end
    end
  end

  assign out_ch.valid   = vld_r[P16];
  assign out_ch.hit     = hit_r;
  assign out_ch.hit_t   = hit_t_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;
  assign out_ch.point_z = pz_r;
  assign out_ch.grad_x  = px_r;
  assign out_ch.grad_y  = gy_r;
  assign out_ch.grad_z  = pz_r;
endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the ray/cone intersection block: table-driven and random rays
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rci_pkg::*;

  typedef logic signed [63:0] q64_t;

  localparam q64_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int   FB    = FRAC_BITS_DEF;
  localparam int   ONE   = 1 << FB;
  localparam int   SETTLE = 160;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic               far_root;
  } ray_t;

  typedef struct {
    logic               hit;
    logic [30:0]        t;
    logic signed [31:0] px, py, pz, gx, gy, gz;
  } hit_rec_t;

  typedef struct {
    ray_t     ray;
    bit       typed;
    hit_rec_t res;
  } row_t;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic pready;

  rci_in_if  ray_bus ();
  rci_out_if hit_bus ();

  ray_cone_intersect DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(ray_bus), .out_ch(hit_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the cone geometry
  logic [30:0] cone_r, cone_h;

  hit_rec_t pending_hits[$];
  int errors, n_hits, n_misses, n_sent;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fixed-point helpers at the block's internal width
  function automatic q64_t sat_sum(q64_t a, q64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Q_MAX)) return Q_MAX;
    if (s < -65'(Q_MAX)) return -Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] absval(q64_t x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic q64_t signed_mag(logic [127:0] m, bit neg);
    q64_t v;
    v = (m > 128'(Q_MAX)) ? Q_MAX : q64_t'(m[63:0]);
    return neg ? -v : v;
  endfunction

  function automatic q64_t qmul(q64_t x, q64_t y);
    logic [127:0] p;
    p = 128'(absval(x)) * 128'(absval(y));
    return signed_mag(p >> FB, (x < 0) != (y < 0));
  endfunction

  function automatic q64_t qdiv(q64_t x, q64_t y);
    logic [127:0] q;
    if (y == 0) return signed_mag({128{1'b1}}, (x < 0) != (y < 0));
    q = (128'(absval(x)) << FB) / 128'(absval(y));
    return signed_mag(q, (x < 0) != (y < 0));
  endfunction

  function automatic q64_t qsqrt(q64_t v);
    logic [127:0] target, cand;
    logic [63:0]  root;
    target = 128'(v) << FB;
    root = '0;
    for (int i = (63 + FB) / 2 + 1; i >= 0; i--) begin
      cand = 128'(root | (64'd1 << i));
      if (cand * cand <= target) root = cand[63:0];
    end
    return q64_t'(root);
  endfunction

  function automatic logic signed [31:0] clamp32(q64_t x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // expected result of one ray against the programmed cone
  function automatic hit_rec_t intersect_cone(ray_t r);
    hit_rec_t e;
    q64_t ox, oy, oz, dx, dy, dz, h, k, hy, a, b, c, ac4, disc, s, den;
    q64_t t0, t1, t, px, py, pz;
    e = '{default: '0};
    ox = r.ox; oy = r.oy; oz = r.oz; dx = r.dx; dy = r.dy; dz = r.dz;
    h = q64_t'({33'd0, cone_h});
    k = qdiv(q64_t'({33'd0, cone_r}), h);
    k = qmul(k, k);
    hy = h - oy;
    a = sat_sum(sat_sum(qmul(dx, dx), qmul(dz, dz)), -qmul(k, qmul(dy, dy)));
    b = sat_sum(qmul(k, qmul(hy, dy)), sat_sum(qmul(ox, dx), qmul(oz, dz)));
    b = sat_sum(b, b);
    c = sat_sum(sat_sum(qmul(ox, ox), qmul(oz, oz)), -qmul(k, qmul(hy, hy)));
    ac4 = qmul(a, c);
    ac4 = sat_sum(ac4, ac4);
    ac4 = sat_sum(ac4, ac4);
    disc = sat_sum(qmul(b, b), -ac4);
    if (disc < 0 || a == 0) return e;
    s = qsqrt(disc);
    den = sat_sum(a, a);
    t0 = qdiv(sat_sum(-b, -s), den);
    t1 = qdiv(sat_sum(-b, s), den);
    if (t0 > t1) begin
      t = t0; t0 = t1; t1 = t;
    end
    t = r.far_root ? t1 : t0;
    if (t < 0) return e;
    px = sat_sum(ox, qmul(dx, t));
    py = sat_sum(oy, qmul(dy, t));
    pz = sat_sum(oz, qmul(dz, t));
    if (py < 0 || py > h) return e;
    e.hit = 1'b1;
    e.t   = (t > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : t[30:0];
    e.px  = clamp32(px);
    e.py  = clamp32(py);
    e.pz  = clamp32(pz);
    e.gx  = clamp32(px);
    e.gy  = clamp32(qmul(k, py - h));
    e.gz  = clamp32(pz);
    return e;
  endfunction

  // register write over the APB port, only while idle
  task automatic write_reg(logic idx, logic [30:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00}); pwdata <= {1'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_RADIUS) cone_r = value;
    else cone_h = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cone(logic [30:0] radius, logic [30:0] height);
    wait_drained();
    write_reg(REG_RADIUS, radius);
    write_reg(REG_HEIGHT, height);
  endtask

  // one ray transfer; valid stays high into the next call when there is no gap
  task automatic send_ray(ray_t r, bit typed, hit_rec_t typed_res);
    @(negedge clk);
    ray_bus.valid <= 1'b1;
    ray_bus.origin_x <= r.ox; ray_bus.origin_y <= r.oy; ray_bus.origin_z <= r.oz;
    ray_bus.dir_x <= r.dx; ray_bus.dir_y <= r.dy; ray_bus.dir_z <= r.dz;
    ray_bus.ray_inside <= r.far_root;
    @(posedge clk);
    while (!ray_bus.ready) @(posedge clk);
    pending_hits.push_back(typed ? typed_res : intersect_cone(r));
    n_sent++;
  endtask

  task automatic idle_sender(int cycles);
    @(negedge clk);
    ray_bus.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic signed [31:0] small_val(int span);
    return 32'($signed($urandom_range(0, 2 * span))) - span;
  endfunction

  // rays aimed through the cone axis most often, loose rays nearly as often, some full-range noise
  function automatic ray_t make_ray();
    ray_t r;
    int mode;
    logic signed [31:0] ty;
    mode = $urandom_range(0, 99);
    r.far_root = $urandom_range(0, 1);
    if (mode < 15) begin
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
    end else if (mode < 55) begin
      r.ox = small_val(4 * ONE); r.oy = small_val(4 * ONE); r.oz = small_val(4 * ONE);
      r.dx = small_val(2 * ONE); r.dy = small_val(2 * ONE); r.dz = small_val(2 * ONE);
    end else begin
      r.ox = small_val(4 * ONE); r.oy = small_val(4 * ONE); r.oz = small_val(4 * ONE);
      ty = (cone_h > 31'(8 * ONE)) ? 32'($urandom_range(0, 8 * ONE))
                                   : 32'($urandom_range(0, cone_h));
      r.dx = -r.ox; r.dy = ty - r.oy; r.dz = -r.oz;
    end
    return r;
  endfunction

  // result check against the oldest expectation
  task automatic cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    hit_rec_t e;
    if (rst_n && hit_bus.valid && hit_bus.ready) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_hits.pop_front();
        cmp("hit", e.hit, hit_bus.hit);
        cmp("hit_t", e.t, hit_bus.hit_t);
        cmp("point_x", e.px, hit_bus.point_x);
        cmp("point_y", e.py, hit_bus.point_y);
        cmp("point_z", e.pz, hit_bus.point_z);
        cmp("grad_x", e.gx, hit_bus.grad_x);
        cmp("grad_y", e.gy, hit_bus.grad_y);
        cmp("grad_z", e.gz, hit_bus.grad_z);
        if (e.hit) n_hits++;
        else n_misses++;
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off to fill the pipeline
  initial begin
    int mode, hold_left;
    bit held;
    hit_bus.ready = 1'b0;
    held = 1'b0;
    hold_left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (!held && n_hits + n_misses >= 150) begin
        held = 1'b1;
        hold_left = 400;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        hit_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: hit_bus.ready <= 1'b1;
          1: hit_bus.ready <= ($urandom_range(0, 9) < 7);
          default: hit_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

  row_t rows[$];

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz, bit ins);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz; r.far_root = ins;
    return r;
  endfunction

  task automatic add_row(ray_t r, bit typed, hit_rec_t res);
    row_t w;
    w.ray = r; w.typed = typed; w.res = res;
    rows.push_back(w);
  endtask

  initial begin
    hit_rec_t miss, near_hit, far_hit;
    logic [30:0] cones[6][2];
    int lo, hi, burst;
    ray_t r;

    errors = 0; n_hits = 0; n_misses = 0; n_sent = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ray_bus.valid = 1'b0;
    ray_bus.origin_x = '0; ray_bus.origin_y = '0; ray_bus.origin_z = '0;
    ray_bus.dir_x = '0; ray_bus.dir_y = '0; ray_bus.dir_z = '0;
    ray_bus.ray_inside = 1'b0;
    cone_r = 31'(ONE);
    cone_h = 31'(ONE);
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset geometry, unit radius and height
    miss = '{default: '0};
    near_hit = '{hit: 1'b1, t: 31'h18000, px: 32'sh8000, py: 32'sh8000, pz: 0,
                 gx: 32'sh8000, gy: -32'sh8000, gz: 0};
    far_hit  = '{hit: 1'b1, t: 31'h28000, px: -32'sh8000, py: 32'sh8000, pz: 0,
                 gx: -32'sh8000, gy: -32'sh8000, gz: 0};
    add_row(mk(2 * ONE, ONE / 2, 0, -ONE, 0, 0, 0), 1, near_hit);
    add_row(mk(2 * ONE, ONE / 2, 0, -ONE, 0, 0, 1), 1, far_hit);
    // zero direction: degenerate quadratic
    add_row(mk(ONE, ONE, ONE, 0, 0, 0, 0), 1, miss);
    // pointing away: negative t
    add_row(mk(2 * ONE, ONE / 2, 0, ONE, 0, 0, 0), 1, miss);
    // above the apex: hit on the upper nappe, y out of range
    add_row(mk(4 * ONE, 2 * ONE, 0, -ONE, 0, 0, 0), 1, miss);
    // through the apex along the axis direction mix
    add_row(mk(0, 2 * ONE, 0, 0, -ONE, 0, 0), 0, miss);
    add_row(mk(0, -ONE, 0, ONE / 4, ONE, 0, 1), 0, miss);
    add_row(mk(0, ONE / 2, 3 * ONE, 0, 0, -ONE, 0), 0, miss);
    // field extremes
    add_row(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, miss);
    add_row(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1), 0, miss);
    add_row(mk(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 1, 1, 0), 0, miss);
    add_row(mk(0, 0, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1), 0, miss);
    add_row(mk(1, 1, 1, -1, -1, -1, 0), 0, miss);
    // tiny direction: its square rounds to zero, a degenerate quadratic
    add_row(mk(2 * ONE, ONE / 2, 0, -1, 0, 0, 0), 0, miss);
    add_row(mk(2 * ONE, ONE / 2, 0, -1, 0, 0, 1), 0, miss);
    add_row(mk(ONE / 4, ONE / 2, ONE / 8, ONE, ONE, ONE, 1), 0, miss);

    foreach (rows[i]) begin
      send_ray(rows[i].ray, rows[i].typed, rows[i].res);
      if (i % 5 == 4) idle_sender($urandom_range(1, 6));
    end
    idle_sender(1);

    // geometry phases, extremes included; zero height saturates the slope
    cones[0] = '{31'(2 * ONE), 31'(3 * ONE)};
    cones[1] = '{31'h7FFF_FFFF, 31'd1};
    cones[2] = '{31'd1, 31'h7FFF_FFFF};
    cones[3] = '{31'(3 * ONE / 2), 31'd0};
    cones[4] = '{31'($urandom_range(ONE / 4, 8 * ONE)), 31'($urandom_range(ONE / 4, 8 * ONE))};
    cones[5] = '{31'(ONE), 31'(ONE)};

    // random rays, sent in bursts with gaps
    for (int p = -1; p < 6; p++) begin
      if (p >= 0) set_cone(cones[p][0], cones[p][1]);
      lo = 0;
      hi = (p == -1) ? 250 : 215;
      while (lo < hi) begin
        burst = $urandom_range(1, 24);
        for (int j = 0; j < burst && lo < hi; j++) begin
          r = make_ray();
          send_ray(r, 1'b0, miss);
          lo++;
        end
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end
      idle_sender(1);
    end

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d rays over 7 cone settings: %0d hits, %0d misses",
             n_sent, n_hits, n_misses);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
